### src/snpn_pkg.sv
// Shared constants, codes and controller/datapath interface types for the prefix search block.
`default_nettype none

package snpn_pkg;

    localparam int DEF_MAX_FILES = 256;
    localparam int DEF_NAME_LEN  = 64;

    localparam int TABLE_SIZE_W = 9;
    localparam int IDX_FIELD_W  = 8;
    localparam int POS_FIELD_W  = 6;
    localparam int BYTE_W       = 8;
    localparam int KIND_W       = 2;
    localparam int COUNT_W      = 9;
    localparam int BOUND_W      = 8;

    // input tdata layout
    localparam int FIDX_LSB   = 0;
    localparam int CPOS_LSB   = FIDX_LSB + IDX_FIELD_W;
    localparam int BYTE_LSB   = CPOS_LSB + POS_FIELD_W;
    localparam int S_TDATA_W  = 24;

    // result tdata layout
    localparam int M_TDATA_W  = 32;
    localparam int M_USED_W   = COUNT_W + 2 * BOUND_W;
    localparam int M_PAD_W    = M_TDATA_W - M_USED_W;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd2;

    // register select bit of paddr
    localparam logic REG_TABLE_SIZE = 1'b0;

    typedef struct packed {
        logic accept;
        logic load_wr;
        logic start;
        logic clear_wr;
        logic rd_low;
        logic rd_high;
        logic low_inc;
        logic high_dec;
        logic fail;
        logic pos_adv;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] in_kind;
        logic              failed;
        logic              clear_last;
        logic              low_gt_high;
        logic              c_gt_b;
        logic              c_eq_b;
        logic              c_lt_b;
        logic              high_eq_low;
    } sts_t;

endpackage

`default_nettype wire

### src/sorted_name_prefix_narrowing.sv
// Top level: incremental prefix search over a sorted name table with APB configuration.
//
//  Channel  Direction  Ports                      Carries
//  s_       in         tvalid/tready/tdata/tuser  load byte, start, or path character
//  m_       out        tvalid/tready/tdata/tuser  match count and bounds per transaction
//  APB      in/out     psel/penable/pwrite/...    table size register at byte address 0
//
//  After reset the name memory is cleared, one byte a cycle, all MAX_FILES*NAME_LEN
//  bytes (16384 at defaults); no transaction is accepted until that pass ends.
//  Load, start and unused kinds pass from idle to the done state. A path character
//  walks the low bound up and then the high bound down, one step at a time:
//  each step is one read of the single memory read port plus one compare.
//  One transaction is worked at a time; a finished result waits in the output
//  register while the next transaction is taken and worked.
`default_nettype none

module sorted_name_prefix_narrowing #(
    parameter int MAX_FILES = snpn_pkg::DEF_MAX_FILES,
    parameter int NAME_LEN  = snpn_pkg::DEF_NAME_LEN
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    // file_index[7:0], char_position[13:8], byte_value[21:14], zero[23:22]
    input  wire  [snpn_pkg::S_TDATA_W-1:0]     s_tdata,
    // kind[1:0]
    input  wire  [snpn_pkg::KIND_W-1:0]        s_tuser,
    input  wire                                s_tlast,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    // match_count[8:0], first_match_res[16:9], last_match[24:17], zero[31:25]
    output logic [snpn_pkg::M_TDATA_W-1:0]     m_tdata,
    // search_failed[0]
    output logic                               m_tuser,
    output logic                               m_tlast,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [snpn_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire  [snpn_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [snpn_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import snpn_pkg::*;

    logic [TABLE_SIZE_W-1:0] table_size_reg;
    logic                    cfg_wr;
    logic                    sel_fc;
    cmd_t                    cmd;
    sts_t                    sts;

    assign pready = 1'b1;
    assign sel_fc = (paddr[2] == REG_TABLE_SIZE);
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = sel_fc ? APB_DATA_W'(table_size_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_size_reg <= '0;
        end else if (cfg_wr && sel_fc) begin
            table_size_reg <= pwdata[TABLE_SIZE_W-1:0];
        end
    end

    snpn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .sts      (sts),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    snpn_dpath #(
        .MAX_FILES (MAX_FILES),
        .NAME_LEN  (NAME_LEN)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .table_size (table_size_reg),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

### src/snpn_dpath.sv
// Datapath: name memory, clearing counter, search bounds, compare logic and result register.
`default_nettype none

module snpn_dpath #(
    parameter int MAX_FILES = snpn_pkg::DEF_MAX_FILES,
    parameter int NAME_LEN  = snpn_pkg::DEF_NAME_LEN
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire  snpn_pkg::cmd_t                  cmd,
    output snpn_pkg::sts_t                        sts,
    input  wire  [snpn_pkg::S_TDATA_W-1:0]        s_tdata,
    input  wire  [snpn_pkg::KIND_W-1:0]           s_tuser,
    input  wire                                   s_tlast,
    input  wire  [snpn_pkg::TABLE_SIZE_W-1:0]     table_size,
    output logic [snpn_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                  m_tuser,
    output logic                                  m_tlast
);
    import snpn_pkg::*;

    localparam int IW    = $clog2(MAX_FILES) + 1;
    localparam int PW    = $clog2(NAME_LEN + 1);
    localparam int DEPTH = MAX_FILES * NAME_LEN;
    localparam int AW    = $clog2(DEPTH);

    logic [BYTE_W-1:0] mem [DEPTH];

    logic [AW-1:0]          clr_reg;
    logic [IW-1:0]          low_reg;
    logic [IW-1:0]          high_reg;
    logic [PW-1:0]          pos_reg;
    logic                   failed_reg;
    logic [BYTE_W-1:0]      char_reg;
    logic                   chunk_reg;
    logic [KIND_W-1:0]      kind_reg;
    logic [BYTE_W-1:0]      rdata_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic [BOUND_W-1:0]     first_reg;
    logic [BOUND_W-1:0]     last_reg;
    logic                   sfail_reg;
    logic                   done_reg;

    logic [IDX_FIELD_W-1:0] in_fidx;
    logic [POS_FIELD_W-1:0] in_cpos;
    logic [BYTE_W-1:0]      in_byte;
    logic                   load_ok;
    logic [AW-1:0]          ld_addr;
    logic [IW-1:0]          rd_idx;
    logic [AW-1:0]          rd_addr;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [BYTE_W-1:0]      wr_data;
    logic                   pos_past;
    logic [BYTE_W-1:0]      cur_byte;
    logic [31:0]            n_clip;

    assign in_fidx = s_tdata[FIDX_LSB +: IDX_FIELD_W];
    assign in_cpos = s_tdata[CPOS_LSB +: POS_FIELD_W];
    assign in_byte = s_tdata[BYTE_LSB +: BYTE_W];

    assign load_ok = (32'(in_fidx) < MAX_FILES) && (32'(in_cpos) < NAME_LEN);
    assign ld_addr = AW'(32'(in_fidx) * 32'(NAME_LEN) + 32'(in_cpos));
    assign rd_idx  = cmd.rd_high ? high_reg : low_reg;
    assign rd_addr = AW'(32'(rd_idx) * 32'(NAME_LEN) + 32'(pos_reg));

    assign wr_en   = cmd.clear_wr || (cmd.load_wr && load_ok);
    assign wr_addr = cmd.clear_wr ? clr_reg : ld_addr;
    assign wr_data = cmd.clear_wr ? '0 : in_byte;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_low || cmd.rd_high) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // bytes past the end of a name read as zero
    assign pos_past = 32'(pos_reg) >= NAME_LEN;
    assign cur_byte = pos_past ? '0 : rdata_reg;

    assign n_clip = (32'(table_size) > MAX_FILES) ? 32'(MAX_FILES) : 32'(table_size);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg    <= '0;
            low_reg    <= '0;
            high_reg   <= '0;
            pos_reg    <= '0;
            failed_reg <= 1'b1;
        end else begin
            if (cmd.clear_wr) begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.start) begin
                pos_reg <= '0;
                low_reg <= '0;
                if (n_clip == 32'd0) begin
                    failed_reg <= 1'b1;
                    high_reg   <= '0;
                end else begin
                    failed_reg <= 1'b0;
                    high_reg   <= IW'(n_clip - 32'd1);
                end
            end else if (cmd.fail) begin
                failed_reg <= 1'b1;
                low_reg    <= '0;
                high_reg   <= '0;
            end else begin
                if (cmd.low_inc) begin
                    low_reg <= low_reg + IW'(1);
                end
                if (cmd.high_dec) begin
                    high_reg <= high_reg - IW'(1);
                end
                if (cmd.pos_adv && !pos_past) begin
                    pos_reg <= pos_reg + PW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            kind_reg  <= s_tuser;
            chunk_reg <= s_tlast;
            char_reg  <= in_byte;
        end
        if (cmd.out_load) begin
            if (failed_reg) begin
                count_reg <= '0;
                first_reg <= '0;
                last_reg  <= '0;
            end else begin
                count_reg <= COUNT_W'(32'(high_reg) - 32'(low_reg) + 32'd1);
                first_reg <= BOUND_W'(low_reg);
                last_reg  <= BOUND_W'(high_reg);
            end
            sfail_reg <= failed_reg;
            done_reg  <= (kind_reg == KIND_CHAR) && chunk_reg;
        end
    end

    assign sts.in_kind     = s_tuser;
    assign sts.failed      = failed_reg;
    assign sts.clear_last  = (clr_reg == AW'(DEPTH - 1));
    assign sts.low_gt_high = low_reg > high_reg;
    assign sts.c_gt_b      = char_reg > cur_byte;
    assign sts.c_eq_b      = char_reg == cur_byte;
    assign sts.c_lt_b      = char_reg < cur_byte;
    assign sts.high_eq_low = high_reg == low_reg;

    assign m_tdata = {M_PAD_W'(0), last_reg, first_reg, count_reg};
    assign m_tuser = sfail_reg;
    assign m_tlast = done_reg;

    a_fail_clears_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        failed_reg |-> (low_reg == '0) && (high_reg == '0))
        else $error("failed search left bounds set");

    a_high_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        !failed_reg |-> (32'(high_reg) < MAX_FILES))
        else $error("high bound beyond table");

    a_pos_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(pos_reg) <= NAME_LEN)
        else $error("search position past saturation");

endmodule

`default_nettype wire

### src/snpn_ctrl.sv
// Controller: clearing pass, per-item sequencing of the bound walk, and result valid.
`default_nettype none

module snpn_ctrl (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire  snpn_pkg::sts_t sts,
    input  wire              s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  wire              m_tready,
    output snpn_pkg::cmd_t   cmd
);
    import snpn_pkg::*;

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_LOW_RD   = 3'd2;
    localparam logic [2:0] S_LOW_CMP  = 3'd3;
    localparam logic [2:0] S_HIGH_RD  = 3'd4;
    localparam logic [2:0] S_HIGH_CMP = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    cmd.accept = 1'b1;
                    state_next = S_DONE;
                    unique case (sts.in_kind)
                        KIND_LOAD:  cmd.load_wr = 1'b1;
                        KIND_START: cmd.start   = 1'b1;
                        KIND_CHAR: begin
                            if (!sts.failed) begin
                                state_next = S_LOW_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LOW_RD: begin
                if (sts.low_gt_high) begin
                    cmd.fail   = 1'b1;
                    state_next = S_DONE;
                end else begin
                    cmd.rd_low = 1'b1;
                    state_next = S_LOW_CMP;
                end
            end
            S_LOW_CMP: begin
                priority if (sts.c_gt_b) begin
                    cmd.low_inc = 1'b1;
                    state_next  = S_LOW_RD;
                end else if (!sts.c_eq_b) begin
                    cmd.fail   = 1'b1;
                    state_next = S_DONE;
                end else begin
                    state_next = S_HIGH_RD;
                end
            end
            S_HIGH_RD: begin
                cmd.rd_high = 1'b1;
                state_next  = S_HIGH_CMP;
            end
            S_HIGH_CMP: begin
                priority if (sts.c_lt_b && sts.high_eq_low) begin
                    cmd.fail   = 1'b1;
                    state_next = S_DONE;
                end else if (sts.c_lt_b) begin
                    cmd.high_dec = 1'b1;
                    state_next   = S_HIGH_RD;
                end else begin
                    cmd.pos_adv = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the result register frees up
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_cmp_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LOW_CMP || state_reg == S_HIGH_CMP) |->
        ($past(state_reg) == S_LOW_RD || $past(state_reg) == S_HIGH_RD))
        else $error("compare without a preceding memory read");

    a_no_clear_with_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_wr |-> !s_tready)
        else $error("input accepted during clearing pass");

    a_result_not_lost: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> out_valid_reg)
        else $error("pending result dropped");

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the sorted name table prefix search block.
`timescale 1ns / 100ps

module tb;
    import snpn_pkg::*;

    localparam int MAX_FILES = DEF_MAX_FILES;
    localparam int NAME_LEN  = DEF_NAME_LEN;
    localparam int NAME_SPAN = 5;        // bytes per generated name, zero padded
    localparam int ITEM_GOAL = 1450;
    localparam logic [KIND_W-1:0]     KIND_UNUSED     = 2'd3;
    localparam logic [APB_ADDR_W-1:0] ADDR_TABLE_SIZE = 3'd0;
    localparam bit [7:0] CHAR_A = 8'h61;

    typedef struct {
        logic [8:0] count;
        logic [7:0] first;
        logic [7:0] last;
        logic       failed;
        logic       done;
    } search_status_t;

    class narrowing_scoreboard;
        bit [7:0]       name_mem [MAX_FILES][NAME_LEN];
        int             low_idx;
        int             high_idx;
        int             path_pos;
        bit             no_match;
        bit [8:0]       table_size;
        search_status_t expected_status[$];
        int             errors;
        int             checked;
        int             failed_seen;

        function new();
            foreach (name_mem[i, j]) name_mem[i][j] = 8'h00;
            low_idx     = 0;
            high_idx    = 0;
            path_pos    = 0;
            no_match    = 1'b1;
            table_size  = 9'd0;
            errors      = 0;
            checked     = 0;
            failed_seen = 0;
        endfunction

        function bit [7:0] byte_at(int idx, int pos);
            if (idx >= MAX_FILES || pos >= NAME_LEN) return 8'h00;
            return name_mem[idx][pos];
        endfunction

        function void abandon();
            no_match = 1'b1;
            low_idx  = 0;
            high_idx = 0;
        endfunction

        // Move the low bound up and the high bound down for one path character.
        function void narrow_bounds(bit [7:0] c);
            int pos;
            pos = path_pos;
            while (low_idx <= high_idx && c > byte_at(low_idx, pos)) low_idx++;
            if (low_idx > high_idx || c != byte_at(low_idx, pos)) begin
                abandon();
                return;
            end
            while (c < byte_at(high_idx, pos)) begin
                if (high_idx == low_idx) begin
                    abandon();
                    return;
                end
                high_idx--;
            end
            if (path_pos < NAME_LEN) path_pos++;
        endfunction

        function void note_item(logic [1:0] kind, logic [7:0] fidx, logic [5:0] cpos,
                                logic [7:0] val, logic cend);
            search_status_t st;
            int n;
            st.done = 1'b0;
            case (kind)
                KIND_LOAD: begin
                    name_mem[fidx][cpos] = val;
                end
                KIND_START: begin
                    n = (table_size > MAX_FILES) ? MAX_FILES : int'(table_size);
                    path_pos = 0;
                    if (n == 0) begin
                        abandon();
                    end else begin
                        no_match = 1'b0;
                        low_idx  = 0;
                        high_idx = n - 1;
                    end
                end
                KIND_CHAR: begin
                    st.done = cend;
                    if (!no_match) narrow_bounds(val);
                end
                default: ;
            endcase
            if (no_match) begin
                st.count  = 9'd0;
                st.first  = 8'd0;
                st.last   = 8'd0;
                st.failed = 1'b1;
            end else begin
                st.count  = 9'(high_idx - low_idx + 1);
                st.first  = 8'(low_idx);
                st.last   = 8'(high_idx);
                st.failed = 1'b0;
            end
            expected_status.push_back(st);
        endfunction

        function void compare_field(string field, logic [8:0] want, logic [8:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata, logic failed, logic done);
            search_status_t st;
            if (expected_status.size() == 0) begin
                $error("result transaction with no input pending");
                errors++;
                return;
            end
            st = expected_status.pop_front();
            checked++;
            if (st.failed) failed_seen++;
            compare_field("match_count", st.count, tdata[8:0]);
            compare_field("first_match_res", 9'(st.first), 9'(tdata[16:9]));
            compare_field("last_match", 9'(st.last), 9'(tdata[24:17]));
            compare_field("search_failed", 9'(st.failed), 9'(failed));
            compare_field("chunk_done", 9'(st.done), 9'(done));
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [KIND_W-1:0]     s_tuser;
    logic                  s_tlast;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    narrowing_scoreboard sb;
    bit steady;
    int items_sent;
    int n_loads, n_starts, n_chars, n_ignored, n_settings;
    bit [39:0] loaded_names[$];

    sorted_name_prefix_narrowing u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #100_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic bit [7:0] pick_char();
        if ($urandom_range(0, 9) < 7) return 8'(CHAR_A + $urandom_range(0, 2));
        return 8'($urandom_range(1, 255));
    endfunction

    // Receiver: mostly ready, with short and occasional long stalls.
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (!steady && $urandom_range(0, 99) < 15) begin
                    stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                           : $urandom_range(10, 40);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_item(s_tuser, s_tdata[7:0], s_tdata[13:8], s_tdata[21:14], s_tlast);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    task automatic send_item(input bit [1:0] kind, input bit [7:0] fidx, input bit [5:0] cpos,
                             input bit [7:0] val, input bit cend);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, val, cpos, fidx};
        s_tuser  <= kind;
        s_tlast  <= cend;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        case (kind)
            KIND_LOAD:  n_loads++;
            KIND_START: n_starts++;
            KIND_CHAR:  n_chars++;
            default:    n_ignored++;
        endcase
        if (kind != KIND_UNUSED) items_sent++;
    endtask

    task automatic start_search();
        send_item(KIND_START, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic path_char(input bit [7:0] val, input bit cend);
        send_item(KIND_CHAR, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)), val, cend);
    endtask

    // Unused kind, or a load into a slot outside the active table.
    task automatic send_noise(input int n);
        int lo;
        lo = (n == 0) ? 1 : n;
        if (lo < MAX_FILES && $urandom_range(0, 1) == 1)
            send_item(KIND_LOAD, 8'($urandom_range(lo, MAX_FILES - 1)),
                      6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
        else
            send_item(KIND_UNUSED, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // Hold the sender until every pending result has been accepted.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_status.size() != 0) @(posedge aclk);
    endtask

    task automatic set_table_size(input int value);
        logic [APB_DATA_W-1:0] wd;
        logic [APB_DATA_W-1:0] rd;
        wd = $urandom();
        wd[8:0] = 9'(value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TABLE_SIZE;
        pwdata  <= wd;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.table_size = wd[8:0];
        n_settings++;
        // read back in a second transfer
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== {{(APB_DATA_W - 9){1'b0}}, wd[8:0]}) begin
            $error("table size readback: expected %0d, got %0d", wd[8:0], rd);
            sb.errors++;
        end
    endtask

    initial begin
        int n, r, nsearch, len, lsize, phase;
        bit [39:0] cand;
        bit [39:0] tgt;
        bit [7:0] ch;
        bit cend;
        bit [39:0] name_set[$];

        sb = new();
        steady     = 1'b0;
        items_sent = 0;
        n_loads = 0; n_starts = 0; n_chars = 0; n_ignored = 0; n_settings = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= KIND_LOAD;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= ADDR_TABLE_SIZE;
        pwdata   <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table, character after failure, unused kind.
        set_table_size(0);
        start_search();
        path_char(CHAR_A, 1'b1);
        send_item(KIND_UNUSED, 8'hFF, 6'h3F, 8'hFF, 1'b1);
        // table "ab", "ac", "b" plus an extreme load far outside it
        send_item(KIND_LOAD, 8'd0, 6'd0, CHAR_A, 1'b0);
        send_item(KIND_LOAD, 8'd0, 6'd1, CHAR_A + 8'd1, 1'b0);
        send_item(KIND_LOAD, 8'd1, 6'd0, CHAR_A, 1'b1);
        send_item(KIND_LOAD, 8'd1, 6'd1, CHAR_A + 8'd2, 1'b0);
        send_item(KIND_LOAD, 8'd2, 6'd0, CHAR_A + 8'd1, 1'b0);
        send_item(KIND_LOAD, 8'd255, 6'd63, 8'hFF, 1'b1);
        loaded_names = '{40'h6162000000, 40'h6163000000, 40'h6200000000};
        wait_drained();
        set_table_size(3);
        start_search();
        path_char(CHAR_A, 1'b0);
        // a load while a search is open must leave the bounds alone
        send_item(KIND_LOAD, 8'd200, 6'd10, 8'h5A, 1'b0);
        path_char(CHAR_A + 8'd2, 1'b1);
        path_char(8'h00, 1'b0);
        start_search();
        path_char(8'h7A, 1'b0);
        path_char(CHAR_A, 1'b1);
        start_search();
        path_char(8'h00, 1'b1);
        wait_drained();
        // oversized count acts as the full table, which is unsorted here
        set_table_size(511);
        start_search();
        path_char(CHAR_A, 1'b0);
        path_char(8'hFF, 1'b1);
        wait_drained();
        set_table_size(1);
        start_search();
        path_char(CHAR_A, 1'b1);

        phase = 0;
        while (items_sent < ITEM_GOAL) begin
            phase++;
            steady = ($urandom_range(0, 9) < 2);
            r = $urandom_range(0, 99);
            if (phase == 1 || r < 70) n = $urandom_range(1, 8);
            else if (r < 78)          n = 0;
            else if (r < 88)          n = $urandom_range(9, 40);
            else if (r < 94)          n = MAX_FILES;
            else                      n = $urandom_range(MAX_FILES + 1, 511);

            if (n >= 1 && n <= 8) begin
                name_set.delete();
                for (int i = 0; i < n; i++) begin
                    len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, NAME_SPAN);
                    cand = '0;
                    for (int p = 0; p < len; p++) cand[39 - 8 * p -: 8] = pick_char();
                    name_set.push_back(cand);
                end
                // empty name first so that a long run of zero characters stays matched
                if (phase == 1) name_set[0] = '0;
                name_set.sort();
                loaded_names = name_set;
                for (int i = 0; i < n; i++) begin
                    for (int p = 0; p < NAME_SPAN; p++) begin
                        send_item(KIND_LOAD, 8'(i), 6'(p), name_set[i][39 - 8 * p -: 8],
                                  1'($urandom_range(0, 1)));
                        if ($urandom_range(0, 99) < 8) send_noise(n);
                    end
                end
            end

            wait_drained();
            set_table_size(n);
            lsize = loaded_names.size();
            nsearch = $urandom_range(2, 6);
            for (int s = 0; s < nsearch; s++) begin
                start_search();
                if ((phase == 1 && s == 0) ||
                    (n >= 1 && n <= 8 && loaded_names[0] == '0 && $urandom_range(0, 49) == 0)) begin
                    // walk past the end of the name; the position saturates
                    for (int k = 0; k < NAME_LEN + 6; k++)
                        path_char(8'h00, 1'(k == NAME_LEN + 5));
                end else begin
                    tgt = loaded_names[$urandom_range(0, lsize - 1)];
                    len = $urandom_range(1, 7);
                    for (int k = 0; k < len; k++) begin
                        ch = (k < NAME_SPAN) ? tgt[39 - 8 * k -: 8] : 8'h00;
                        if ($urandom_range(0, 99) < 12)
                            ch = ($urandom_range(0, 1) == 1) ? pick_char()
                                                             : 8'($urandom_range(0, 255));
                        cend = (k == len - 1) ? 1'b1 : ($urandom_range(0, 4) == 0);
                        path_char(ch, cend);
                        if ($urandom_range(0, 99) < 5) send_noise(n);
                    end
                end
                if ($urandom_range(0, 99) < 5) wait_drained();
            end
        end

        wait_drained();
        steady = 1'b0;
        repeat (40) @(posedge aclk);
        $display("Covered %0d loads, %0d starts, %0d path characters, %0d ignored items",
                 n_loads, n_starts, n_chars, n_ignored);
        $display("over %0d table size settings; %0d results checked, %0d of them failed searches",
                 n_settings, sb.checked, sb.failed_seen);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
